FILE: sv/wis_pkg.sv
// ----------------------------------------------------------------------------
// wis_pkg
// Shared sizes, divider request/response types and helpers for the windowed
// interval statistics block.
// ----------------------------------------------------------------------------
package wis_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int SUM_W      = 16 + $clog2(TABLE_SIZE);
  localparam int SQ_W       = 32 + $clog2(TABLE_SIZE);
  localparam int STEP_W     = $clog2(SQ_W + 1);

  typedef struct packed {
    logic              start;
    logic [SQ_W-1:0]   dividend;
    logic [SUM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [SQ_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [15:0] sat16(input logic [SQ_W-1:0] v);
    sat16 = (|v[SQ_W-1:16]) ? 16'hFFFF : v[15:0];
  endfunction

endpackage

FILE: sv/wis_ram.sv
// ----------------------------------------------------------------------------
// wis_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/wis_div.sv
// ----------------------------------------------------------------------------
// wis_div
// Iterative restoring divider, one quotient bit per cycle. The dividend is
// left-aligned by the caller; steps sets how many bits are developed.
// ----------------------------------------------------------------------------
module wis_div (
  input  logic              clk,
  input  logic              rst_n,
  input  wis_pkg::div_req_t req,
  output wis_pkg::div_rsp_t rsp
);

  logic                       busy_r;
  logic                       done_r;
  logic [wis_pkg::STEP_W-1:0] cnt_r;
  logic [wis_pkg::SQ_W-1:0]   dvd_r;
  logic [wis_pkg::SQ_W-1:0]   quo_r;
  logic [wis_pkg::SUM_W-1:0]  rem_r;
  logic [wis_pkg::SUM_W-1:0]  dvs_r;
  logic [wis_pkg::SUM_W:0]    shifted;
  logic [wis_pkg::SUM_W:0]    diff;

  assign shifted = {rem_r, dvd_r[wis_pkg::SQ_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - wis_pkg::STEP_W'(1);
        if (cnt_r == wis_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[wis_pkg::SQ_W-2:0], 1'b0};
      if (!diff[wis_pkg::SUM_W]) begin
        rem_r <= diff[wis_pkg::SUM_W-1:0];
        quo_r <= {quo_r[wis_pkg::SQ_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[wis_pkg::SUM_W-1:0];
        quo_r <= {quo_r[wis_pkg::SQ_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

FILE: sv/windowed_interval_statistics.sv
// ----------------------------------------------------------------------------
// windowed_interval_statistics
// Sliding window of interval samples with running sum, sum of squares,
// plain and weighted averages and window maxima.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall   sample_ms
//  out_     output     out_valid / out_stall mean_interval, weighted_mean,
//                                            peak_ever, peak_recent
//
// After reset the ring is cleared, one entry a cycle, with in_stall high.
// Between one sample transfer and the next, the shared divider runs the mean
// quotient and then the weighted quotient one bit per cycle; a held mean or a
// zero sum skips its quotient. The result sits in an output register; a
// stalled result holds the block before its next output only.
// ----------------------------------------------------------------------------
module windowed_interval_statistics (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_sample_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_mean_interval,
  output logic [15:0] out_weighted_mean,
  output logic [15:0] out_peak_ever,
  output logic [15:0] out_peak_recent
);

  localparam logic [3:0] ST_CLEAR     = 4'd0;
  localparam logic [3:0] ST_IDLE      = 4'd1;
  localparam logic [3:0] ST_SQ_OLD    = 4'd2;
  localparam logic [3:0] ST_SQ_NEW    = 4'd3;
  localparam logic [3:0] ST_MEAN      = 4'd4;
  localparam logic [3:0] ST_MEAN_WAIT = 4'd5;
  localparam logic [3:0] ST_WGT       = 4'd6;
  localparam logic [3:0] ST_WGT_WAIT  = 4'd7;
  localparam logic [3:0] ST_OUT       = 4'd8;

  localparam logic [wis_pkg::SLOT_W-1:0] LAST_SLOT =
    wis_pkg::SLOT_W'(wis_pkg::TABLE_SIZE - 1);

  logic [3:0]                 state_r;
  logic [3:0]                 state_nxt;
  logic [wis_pkg::SLOT_W-1:0] clr_cnt_r;
  logic [wis_pkg::SLOT_W-1:0] slot_r;
  logic [15:0]                s_r;
  logic [wis_pkg::SUM_W-1:0]  sum_r;
  logic [wis_pkg::SQ_W-1:0]   sq_r;
  logic                       last_nz_r;
  logic [15:0]                held_mean_r;
  logic [15:0]                weighted_r;
  logic [15:0]                max_all_r;
  logic [15:0]                max_win_r;
  logic [15:0]                max_prior_r;
  logic                       out_valid_r;
  logic [15:0]                out_mean_r;
  logic [15:0]                out_wgt_r;
  logic [15:0]                out_peak_r;
  logic [15:0]                out_recent_r;

  logic                       in_xfer;
  logic                       out_xfer;
  logic                       ram_we;
  logic [wis_pkg::SLOT_W-1:0] ram_addr;
  logic [15:0]                ram_wdata;
  logic [15:0]                old_q;
  logic [15:0]                mop;
  logic [31:0]                prod;
  logic [15:0]                max_win_up;
  logic                       mean_go;
  wis_pkg::div_req_t          div_req;
  wis_pkg::div_rsp_t          div_rsp;

  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;

  assign mean_go    = last_nz_r || (slot_r != '0);
  assign max_win_up = (s_r > max_win_r) ? s_r : max_win_r;
  assign mop        = (state_r == ST_SQ_OLD) ? old_q : s_r;
  assign prod       = {16'd0, mop} * {16'd0, mop};

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = slot_r;
    ram_wdata = s_r;
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_r;
      ram_wdata = '0;
    end else if (state_r == ST_SQ_OLD) begin
      ram_we = 1'b1;
    end
  end

  wis_ram #(
    .WIDTH (16),
    .DEPTH (wis_pkg::TABLE_SIZE)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (old_q)
  );

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = {sum_r, {(wis_pkg::SQ_W - wis_pkg::SUM_W){1'b0}}};
    div_req.steps    = wis_pkg::STEP_W'(wis_pkg::SUM_W);
    div_req.divisor  = last_nz_r ? wis_pkg::SUM_W'(wis_pkg::TABLE_SIZE)
                                 : wis_pkg::SUM_W'(slot_r);
    if (state_r == ST_MEAN) begin
      div_req.start = mean_go;
    end else if (state_r == ST_WGT) begin
      div_req.start    = (sum_r != '0);
      div_req.dividend = sq_r;
      div_req.steps    = wis_pkg::STEP_W'(wis_pkg::SQ_W);
      div_req.divisor  = sum_r;
    end
  end

  wis_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (clr_cnt_r == LAST_SLOT) state_nxt = ST_IDLE;
      ST_IDLE:      if (in_xfer) state_nxt = ST_SQ_OLD;
      ST_SQ_OLD:    state_nxt = ST_SQ_NEW;
      ST_SQ_NEW:    state_nxt = ST_MEAN;
      ST_MEAN:      state_nxt = mean_go ? ST_MEAN_WAIT : ST_WGT;
      ST_MEAN_WAIT: if (div_rsp.done) state_nxt = ST_WGT;
      ST_WGT:       state_nxt = (sum_r != '0) ? ST_WGT_WAIT : ST_OUT;
      ST_WGT_WAIT:  if (div_rsp.done) state_nxt = ST_OUT;
      ST_OUT:       if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:      state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      last_nz_r   <= 1'b0;
      held_mean_r <= '0;
      max_all_r   <= '0;
      max_win_r   <= '0;
      max_prior_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + wis_pkg::SLOT_W'(1);
      end
      if (state_r == ST_SQ_OLD) begin
        sum_r <= sum_r - wis_pkg::SUM_W'(old_q) + wis_pkg::SUM_W'(s_r);
        sq_r  <= sq_r - wis_pkg::SQ_W'(prod);
        if (s_r > max_all_r) begin
          max_all_r <= s_r;
        end
        if (slot_r == LAST_SLOT) begin
          last_nz_r   <= (s_r != '0);
          slot_r      <= '0;
          max_prior_r <= max_win_up;
          max_win_r   <= '0;
        end else begin
          slot_r    <= slot_r + wis_pkg::SLOT_W'(1);
          max_win_r <= max_win_up;
        end
      end
      if (state_r == ST_SQ_NEW) begin
        sq_r <= sq_r + wis_pkg::SQ_W'(prod);
      end
      if (state_r == ST_MEAN_WAIT && div_rsp.done) begin
        held_mean_r <= wis_pkg::sat16(div_rsp.quotient);
      end
      if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s_r <= in_sample_ms;
    end
    if (state_r == ST_WGT && sum_r == '0) begin
      weighted_r <= '0;
    end else if (state_r == ST_WGT_WAIT && div_rsp.done) begin
      weighted_r <= wis_pkg::sat16(div_rsp.quotient);
    end
    if (state_r == ST_OUT && (!out_valid_r || !out_stall)) begin
      out_mean_r   <= held_mean_r;
      out_wgt_r    <= weighted_r;
      out_peak_r   <= max_all_r;
      out_recent_r <= (max_win_r > max_prior_r) ? max_win_r : max_prior_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_mean_interval = out_mean_r;
  assign out_weighted_mean = out_wgt_r;
  assign out_peak_ever     = out_peak_r;
  assign out_peak_recent   = out_recent_r;

  a_recent_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_peak_recent <= out_peak_ever))
    else $error("recent peak above all-time peak");

  a_sum_le_sq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (wis_pkg::SQ_W'(sum_r) <= sq_r))
    else $error("window sum exceeds sum of squares");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_MEAN_WAIT || state_r == ST_WGT_WAIT))
    else $error("divider finished outside a wait state");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: windowed interval statistics testbench
// Feeds interval samples through the valid/stall input channel and checks every
// result transfer against a cycle-free model of the sample window. The model
// covers the ring, the running sums, the held mean and the window maxima.
// Stimulus covers field extremes, a partial refill that saturates the mean,
// a long output hold and random traffic with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RING         = wis_pkg::TABLE_SIZE;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int RANDOM_ITEMS = 330;

  typedef struct packed {
    logic [15:0] mean;
    logic [15:0] weighted;
    logic [15:0] peak_all;
    logic [15:0] peak_win;
  } stats_t;

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [15:0] in_sample_ms = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [15:0] out_mean_interval;
  logic [15:0] out_weighted_mean;
  logic [15:0] out_peak_ever;
  logic [15:0] out_peak_recent;

  logic idle_en    = 1'b0;
  logic hold_start = 1'b0;
  int   hold_left  = 0;
  int   mismatches = 0;
  int   cycles     = 0;

  // window model
  logic [15:0] ring_copy [RING];
  int unsigned slot_next;
  logic [63:0] sum_now;
  logic [63:0] sq_now;
  logic [15:0] mean_held;
  logic [15:0] peak_since_reset;
  logic [15:0] peak_window;
  logic [15:0] peak_last_window;
  stats_t      stats_due [$];

  windowed_interval_statistics uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample_ms      (in_sample_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_mean_interval (out_mean_interval),
    .out_weighted_mean (out_weighted_mean),
    .out_peak_ever     (out_peak_ever),
    .out_peak_recent   (out_peak_recent)
  );

  always #5 clk = ~clk;

  function automatic logic [15:0] clip16(input logic [63:0] v);
    return (v > 64'd65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic stats_t advance_window(input logic [15:0] s);
    logic [63:0] old_v;
    logic [63:0] new_v;
    stats_t      r;
    old_v   = 64'(ring_copy[slot_next]);
    new_v   = 64'(s);
    sum_now = sum_now - old_v + new_v;
    sq_now  = sq_now - old_v * old_v + new_v * new_v;
    ring_copy[slot_next] = s;
    if (s > peak_since_reset) peak_since_reset = s;
    if (s > peak_window) peak_window = s;
    slot_next++;
    if (slot_next >= RING) begin
      slot_next        = 0;
      peak_last_window = peak_window;
      peak_window      = '0;
    end
    if (ring_copy[RING-1] != '0) begin
      mean_held = clip16(sum_now / 64'(RING));
    end else if (slot_next != 0) begin
      mean_held = clip16(sum_now / 64'(slot_next));
    end
    r.mean     = mean_held;
    r.weighted = (sum_now == 0) ? 16'h0000 : clip16(sq_now / sum_now);
    r.peak_all = peak_since_reset;
    r.peak_win = (peak_window > peak_last_window) ? peak_window : peak_last_window;
    return r;
  endfunction

  function automatic logic [15:0] pick_sample();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 30) return 16'($urandom);
    else if (k < 55) return 16'($urandom_range(0, 255));
    else if (k < 65) return 16'h0000;
    else if (k < 72) return 16'hFFFF;
    else return 16'($urandom_range(200, 5000));
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic send_sample(input logic [15:0] s);
    in_valid     <= 1'b1;
    in_sample_ms <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    stats_due.push_back(advance_window(s));
  endtask

  task automatic sender_gap();
    int n;
    n = 0;
    if (idle_en && $urandom_range(0, 1) == 1) n = $urandom_range(1, 84);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (stats_due.size() != 0);
  endtask

  task automatic test_extremes();
    logic [15:0] vals [15] = '{16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                               16'h7FFF, 16'hAAAA, 16'h5555, 16'hFFFE, 16'h0002,
                               16'h0000, 16'h00FF, 16'hFF00, 16'h1234, 16'hFFFF};
    idle_en <= 1'b1;
    foreach (vals[i]) begin
      sender_gap();
      send_sample(vals[i]);
    end
  endtask

  // fill up to the last entry with large samples and write zero there: the
  // fill count restarts while older entries remain, so the mean saturates
  task automatic test_partial_fill_overflow();
    idle_en <= 1'b0;
    while (slot_next != RING - 1) send_sample(16'($urandom_range(20000, 65535)));
    send_sample(16'h0000);
    repeat (4) send_sample(16'($urandom_range(0, 100)));
  endtask

  task automatic test_output_hold();
    drain_results();
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (8) send_sample(pick_sample());
    drain_results();
  endtask

  task automatic test_random_traffic();
    idle_en <= 1'b0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 150) idle_en <= 1'b1;
      sender_gap();
      send_sample(pick_sample());
    end
  endtask

  // receiver: long hold-off on request, random stalls while idling is enabled
  always @(posedge clk) begin
    if (hold_start) hold_left <= HOLD_CYCLES;
    else if (hold_left > 0) hold_left <= hold_left - 1;
    out_stall <= hold_start || hold_left > 1 ||
                 (idle_en && $urandom_range(0, 99) < 23);
  end

  always @(posedge clk) begin
    stats_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (stats_due.size() == 0) begin
        report_mismatch($sformatf("result transfer with none expected, mean %0d",
                                  out_mean_interval));
      end else begin
        want = stats_due.pop_front();
        check_field("mean_interval", out_mean_interval, want.mean);
        check_field("weighted_mean", out_weighted_mean, want.weighted);
        check_field("peak_ever", out_peak_ever, want.peak_all);
        check_field("peak_recent", out_peak_recent, want.peak_win);
      end
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[windowed_interval_statistics] ERROR");
    $finish;
  end

  initial begin
    foreach (ring_copy[i]) ring_copy[i] = '0;
    slot_next        = 0;
    sum_now          = '0;
    sq_now           = '0;
    mean_held        = '0;
    peak_since_reset = '0;
    peak_window      = '0;
    peak_last_window = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_extremes();
    test_partial_fill_overflow();
    test_output_hold();
    test_random_traffic();
    drain_results();
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("[windowed_interval_statistics] OK");
    end else begin
      $display("[windowed_interval_statistics] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/wis_pkg.sv
sv/wis_ram.sv
sv/wis_div.sv
sv/windowed_interval_statistics.sv
dv/tb.sv
